@@ sv/cqp_pkg.sv @@
// Package for the circular queue with peek: command codes, limits and controller states.
package cqp_pkg;

    // Command codes carried on the input channel
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_NOP = 2'd2;

    // Capacity register
    localparam int          CAP_W     = 4;
    localparam logic [3:0]  CAP_RESET = 4'd15;

    // Data word and the empty marker
    localparam int           DATA_W      = 32;
    localparam logic [31:0]  EMPTY_VALUE = 32'hFFFF_FFFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

@@ sv/circular_queue_with_peek_core.sv @@
// Circular queue with peek: ring buffer FIFO with a status report on every transfer.
// Path from input transfer to m_valid: pointers and write at the transfer,
// then read, then load.
// The input takes a new item only while idle; the slot memory read sits in a
// state of its own after the pointer update, and the next item waits for the result register.
// Reset (synchronous, active low): head and tail cleared, capacity 15, no result pending;
// slot memory is not cleared and holds garbage until written.
module circular_queue_with_peek_core #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cqp_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic signed [cqp_pkg::DATA_W-1:0] s_push_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_accepted,
    output logic signed [cqp_pkg::DATA_W-1:0] m_front_value,
    output logic signed [cqp_pkg::DATA_W-1:0] m_rear_value,
    output logic                             m_is_empty,
    output logic                             m_is_full
);

    localparam int PW = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW = (PW + 1 > cqp_pkg::CAP_W + 1) ? PW + 1 : cqp_pkg::CAP_W + 1;
    localparam logic [SW-1:0] MAX_SLOTS_W = SW'(MAX_SLOTS);

    cqp_pkg::state_t state_reg, state_next;

    logic [cqp_pkg::CAP_W-1:0] cap_reg;
    logic [PW-1:0]             head_reg, head_next;
    logic [PW-1:0]             tail_reg, tail_next;
    logic                      ok_reg, ok_next;

    logic signed [cqp_pkg::DATA_W-1:0] mem [MAX_SLOTS];
    logic signed [cqp_pkg::DATA_W-1:0] rd_front_reg;
    logic signed [cqp_pkg::DATA_W-1:0] rd_rear_reg;

    logic                              m_valid_reg;
    logic                              accepted_reg;
    logic signed [cqp_pkg::DATA_W-1:0] front_reg;
    logic signed [cqp_pkg::DATA_W-1:0] rear_reg;
    logic                              empty_reg;
    logic                              full_reg;

    logic [SW-1:0] cap_plus;
    logic [SW-1:0] slots;
    logic [SW-1:0] head_inc;
    logic [SW-1:0] tail_inc;
    logic [PW-1:0] head_adv;
    logic [PW-1:0] tail_adv;
    logic [PW-1:0] last_idx;
    logic          q_empty;
    logic          q_full;
    logic          in_xfer;
    logic          do_write;
    logic          rd_en;
    logic          load_out;

    // Active ring size: capacity plus the spare slot, limited by storage
    assign cap_plus = SW'(cap_reg) + SW'(1);
    assign slots    = (cap_plus > MAX_SLOTS_W) ? MAX_SLOTS_W : cap_plus;

    // Advance pointers with wrap at the ring size
    assign head_inc = SW'(head_reg) + SW'(1);
    assign tail_inc = SW'(tail_reg) + SW'(1);
    assign head_adv = (head_inc >= slots) ? '0 : head_inc[PW-1:0];
    assign tail_adv = (tail_inc >= slots) ? '0 : tail_inc[PW-1:0];

    // Newest entry sits one behind the tail
    always_comb begin
        last_idx = tail_reg - PW'(1);
        if (tail_reg == '0) begin
            last_idx = PW'(slots - SW'(1));
        end
    end

    assign q_empty = (head_reg == tail_reg);
    assign q_full  = (tail_adv == head_reg);
    assign in_xfer = s_valid && s_ready;

    // Decide the operation on the current pointers
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        ok_next   = 1'b1;
        do_write  = 1'b0;
        unique case (s_cmd)
            cqp_pkg::CMD_ENQ: begin
                if (q_full) begin
                    ok_next = 1'b0;
                end else begin
                    do_write  = in_xfer;
                    tail_next = tail_adv;
                end
            end
            cqp_pkg::CMD_DEQ: begin
                if (q_empty) begin
                    ok_next = 1'b0;
                end else begin
                    head_next = head_adv;
                end
            end
            default: begin
                ok_next = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cqp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cqp_pkg::ST_READ;
                end
            end
            cqp_pkg::ST_READ: begin
                state_next = cqp_pkg::ST_DONE;
            end
            cqp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cqp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cqp_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            cqp_pkg::ST_IDLE: s_ready  = 1'b1;
            cqp_pkg::ST_READ: rd_en    = 1'b1;
            cqp_pkg::ST_DONE: load_out = !m_valid_reg || m_ready;
            default: s_ready = 1'b0;
        endcase
    end

    // Control registers: state, capacity, pointers, status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cqp_pkg::ST_IDLE;
            cap_reg     <= cqp_pkg::CAP_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                // Capacity write empties the queue
                cap_reg  <= cfg_wr_data;
                head_reg <= '0;
                tail_reg <= '0;
            end else if (in_xfer) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                ok_reg   <= ok_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Slot memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[tail_reg] <= s_push_value;
        end
        if (rd_en) begin
            rd_front_reg <= mem[head_reg];
            rd_rear_reg  <= mem[last_idx];
        end
    end

    // Result register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (load_out) begin
            accepted_reg <= ok_reg;
            empty_reg    <= q_empty;
            full_reg     <= q_full;
            front_reg    <= q_empty ? cqp_pkg::EMPTY_VALUE : rd_front_reg;
            rear_reg     <= q_empty ? cqp_pkg::EMPTY_VALUE : rd_rear_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = accepted_reg;
    assign m_front_value = front_reg;
    assign m_rear_value  = rear_reg;
    assign m_is_empty    = empty_reg;
    assign m_is_full     = full_reg;

`ifndef NO_ASSERTIONS
    // Pointers stay inside the active ring
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW'(head_reg) < slots) && (SW'(tail_reg) < slots))
        else $error("queue pointer outside active ring");

    // An input transfer always moves on to the memory read
    a_xfer_read: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == cqp_pkg::ST_READ))
        else $error("input transfer not followed by read");

    // A dequeue never moves the tail
    a_deq_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_cmd == cqp_pkg::CMD_DEQ) && !cfg_wr_en) |=> $stable(tail_reg))
        else $error("dequeue changed the tail");

    // An empty report carries the empty marker on both values
    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |->
            ((m_front_value == cqp_pkg::EMPTY_VALUE) && (m_rear_value == cqp_pkg::EMPTY_VALUE)))
        else $error("empty report without empty marker");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for circular_queue_with_peek_core: scoreboard, random traffic, stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_SLOTS    = 16;
    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         IDLE_PCT     = 20;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         PHASE_ITEMS  = 50;
    localparam int         NUM_PHASES   = 8;

    typedef struct packed {
        logic                              accepted;
        logic signed [cqp_pkg::DATA_W-1:0] front_value;
        logic signed [cqp_pkg::DATA_W-1:0] rear_value;
        logic                              is_empty;
        logic                              is_full;
    } queue_status_t;

    // Tracks the ring contents and holds the status expected for each input transfer
    class queue_scoreboard;
        logic [cqp_pkg::DATA_W-1:0] ring [MAX_SLOTS];
        int unsigned                head;
        int unsigned                tail;
        logic [cqp_pkg::CAP_W-1:0]  capacity;
        queue_status_t              expected_status [$];
        int                         errors;

        function new();
            head     = 0;
            tail     = 0;
            capacity = cqp_pkg::CAP_RESET;
            errors   = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function void set_capacity(logic [cqp_pkg::CAP_W-1:0] value);
            capacity = value;
            head     = 0;
            tail     = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // Slots in use: one more than the capacity, bounded by the storage
        function int unsigned ring_size();
            int unsigned n;
            n = int'(capacity) + 1;
            return (n > MAX_SLOTS) ? MAX_SLOTS : n;
        endfunction

        function int unsigned next_index(int unsigned idx, int unsigned n);
            return (idx + 1 >= n) ? 0 : idx + 1;
        endfunction

        // Apply one command and queue the status it must produce
        function void note_transfer(logic [1:0] cmd, logic [cqp_pkg::DATA_W-1:0] value);
            int unsigned   n;
            queue_status_t st;
            n = ring_size();
            if (head >= n) head = 0;
            if (tail >= n) tail = 0;
            st.accepted = 1'b1;
            case (cmd)
                cqp_pkg::CMD_ENQ: begin
                    if (next_index(tail, n) == head) begin
                        st.accepted = 1'b0;
                    end else begin
                        ring[tail] = value;
                        tail       = next_index(tail, n);
                    end
                end
                cqp_pkg::CMD_DEQ: begin
                    if (head == tail) begin
                        st.accepted = 1'b0;
                    end else begin
                        head = next_index(head, n);
                    end
                end
                default: ;
            endcase
            st.is_empty = (head == tail);
            st.is_full  = (next_index(tail, n) == head);
            if (st.is_empty) begin
                st.front_value = cqp_pkg::EMPTY_VALUE;
                st.rear_value  = cqp_pkg::EMPTY_VALUE;
            end else begin
                st.front_value = ring[head];
                st.rear_value  = ring[(tail == 0) ? n - 1 : tail - 1];
            end
            expected_status.push_back(st);
        endfunction

        function void compare_field(string field, logic [cqp_pkg::DATA_W-1:0] want,
                                    logic [cqp_pkg::DATA_W-1:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0h, actual %0h", field, want, got);
            end
        endfunction

        // Compare one status transfer with the oldest expectation
        function void check_status(queue_status_t got);
            queue_status_t want;
            if (expected_status.size() == 0) begin
                errors++;
                $error("status transfer with no outstanding command");
                return;
            end
            want = expected_status.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("rear_value", want.rear_value, got.rear_value);
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
        endfunction
    endclass

    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              cfg_wr_en    = 1'b0;
    logic [cqp_pkg::CAP_W-1:0]         cfg_wr_data  = '0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [1:0]                        s_cmd        = cqp_pkg::CMD_NOP;
    logic signed [cqp_pkg::DATA_W-1:0] s_push_value = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic                              m_accepted;
    logic signed [cqp_pkg::DATA_W-1:0] m_front_value;
    logic signed [cqp_pkg::DATA_W-1:0] m_rear_value;
    logic                              m_is_empty;
    logic                              m_is_full;

    bit              idle_on      = 1'b1;
    int              quiet_cycles = 0;
    queue_scoreboard board;

    circular_queue_with_peek_core #(
        .MAX_SLOTS (MAX_SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_transfer(s_cmd, s_push_value);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_status({m_accepted, m_front_value, m_rear_value,
                                m_is_empty, m_is_full});
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one command, with a random gap ahead of it, and hold it until the transfer
    task automatic send_item(logic [1:0] cmd, logic [cqp_pkg::DATA_W-1:0] value);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_push_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the input until every expected status has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
        @(posedge aclk);
    endtask

    task automatic write_capacity(logic [cqp_pkg::CAP_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        board.set_capacity(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Runs of mostly enqueues or mostly dequeues, so the queue swings between empty and full
    task automatic run_phase(int items);
        int                         run_left;
        bit                         fill;
        int unsigned                pick;
        logic [1:0]                 cmd;
        logic [cqp_pkg::DATA_W-1:0] value;
        run_left = 0;
        fill     = 1'b1;
        for (int i = 0; i < items; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(board.capacity + 2, 1);
                fill     = 1'($urandom_range(1));
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 80)      cmd = fill ? cqp_pkg::CMD_ENQ : cqp_pkg::CMD_DEQ;
            else if (pick < 90) cmd = fill ? cqp_pkg::CMD_DEQ : cqp_pkg::CMD_ENQ;
            else if (pick < 96) cmd = cqp_pkg::CMD_NOP;
            else                cmd = CMD_SPARE;
            case ($urandom_range(9))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = cqp_pkg::EMPTY_VALUE;
                default: value = $urandom;
            endcase
            send_item(cmd, value);
        end
    endtask

    initial begin
        logic [cqp_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];
        board = new();
        phase_caps = '{4'd15, 4'd1, 4'd0, 4'd15, 4'd7, 4'd2, 4'd0, 4'd14};
        phase_caps[6] = 4'($urandom_range(15));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue: refused dequeue, then both no-op codes
        send_item(cqp_pkg::CMD_DEQ, 32'h1234_5678);
        send_item(cqp_pkg::CMD_NOP, 32'hDEAD_BEEF);
        send_item(CMD_SPARE, 32'h0BAD_F00D);
        // Extreme values through the default capacity
        send_item(cqp_pkg::CMD_ENQ, 32'h7FFF_FFFF);
        send_item(cqp_pkg::CMD_ENQ, 32'h8000_0000);
        send_item(cqp_pkg::CMD_ENQ, cqp_pkg::EMPTY_VALUE);
        send_item(cqp_pkg::CMD_ENQ, 32'h0000_0000);
        send_item(cqp_pkg::CMD_ENQ, 32'h0000_0001);
        send_item(cqp_pkg::CMD_DEQ, 32'hFFFF_0000);
        send_item(cqp_pkg::CMD_DEQ, 32'h0000_FFFF);
        send_item(cqp_pkg::CMD_NOP, 32'h5555_5555);

        // Capacity one: full after one entry
        write_capacity(4'd1);
        send_item(cqp_pkg::CMD_ENQ, 32'hAAAA_AAAA);
        send_item(cqp_pkg::CMD_ENQ, 32'h5555_5555);
        send_item(cqp_pkg::CMD_DEQ, 32'h0);
        send_item(cqp_pkg::CMD_DEQ, 32'h0);

        // Capacity zero: empty and full at once, enqueue and dequeue refused
        write_capacity(4'd0);
        send_item(cqp_pkg::CMD_ENQ, 32'h1357_9BDF);
        send_item(cqp_pkg::CMD_DEQ, 32'h0);
        send_item(cqp_pkg::CMD_NOP, 32'h0);

        // Random phases over several capacities; one phase runs without stalls
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            idle_on = (p != 3);
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
